// File: src/afr_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte update for the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

	localparam logic [7:0]  START_BYTE     = 8'hAA;
	localparam logic [7:0]  BROADCAST_ADDR = 8'hFF;
	localparam logic [9:0]  FRAME_OVERHEAD = 10'd5;
	localparam logic [8:0]  HEADER_BYTES   = 9'd3;
	localparam logic [8:0]  POS_MAX        = 9'd511;
	localparam logic [15:0] CRC_POLY       = 16'h1021;
	localparam logic [7:0]  DEVICE_ID_RST  = 8'd1;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEVICE_ID      = 8'd0,
		REG_CRC_HIGH_FIRST = 8'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED      = 3'd0,
		ST_TOO_SHORT     = 3'd1,
		ST_BAD_START     = 3'd2,
		ST_BAD_LENGTH    = 3'd3,
		ST_CRC_MISMATCH  = 3'd4,
		ST_NOT_ADDRESSED = 3'd5,
		ST_PAYLOAD_SHORT = 3'd6
	} status_t;

	typedef enum logic {
		KIND_DATA    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} in_beat_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		status_t     status;
		logic [7:0]  command;
		logic [15:0] chan_mask;
		logic        broadcast;
		logic [7:0]  data_count;
	} res_beat_t;

	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: src/afr_in_stage.sv
// Input register stage: holds one accepted byte beat until the frame logic takes it.
`timescale 1ns / 1ps
`default_nettype none

module afr_in_stage
	import afr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire in_beat_t in_beat,
	input  wire logic     advance,
	output logic          in_stall,
	output logic          valid_s1,
	output in_beat_t      beat_s1
);

	logic accept;

	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

`default_nettype wire

// File: src/afr_frame_core.sv
// Frame tracking, CRC accumulation, configuration registers and result forming.
`timescale 1ns / 1ps
`default_nettype none

module afr_frame_core
	import afr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire in_beat_t              beat,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       res_valid,
	output res_beat_t                  res
);

	logic [7:0]  device_id_q;
	logic        crc_high_first_q;

	logic [8:0]  pos_q;
	logic        start_ok_q;
	logic [7:0]  addr_q;
	logic [7:0]  len_q;
	logic [15:0] crc_q;
	logic [15:0] rcrc_q;
	logic [7:0]  cmd_q;
	logic [15:0] mask_q;
	logic [7:0]  fwd_q;

	logic [8:0]  pos_d;
	logic        start_ok_d;
	logic [7:0]  addr_d;
	logic [7:0]  len_d;
	logic [15:0] crc_d;
	logic [15:0] rcrc_d;
	logic [7:0]  cmd_d;
	logic [15:0] mask_d;
	logic [7:0]  fwd_d;

	logic [7:0]  b;
	logic [8:0]  hdr_end;
	logic [8:0]  idx;
	logic        emit_data;
	logic        bc;
	status_t     st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q      <= DEVICE_ID_RST;
			crc_high_first_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_ID:      device_id_q      <= cfg_data[7:0];
				REG_CRC_HIGH_FIRST: crc_high_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign b       = beat.rx_byte;
	assign hdr_end = {1'b0, len_q} + HEADER_BYTES;
	assign idx     = pos_q - HEADER_BYTES;

	always_comb begin
		start_ok_d = start_ok_q;
		addr_d     = addr_q;
		len_d      = len_q;
		crc_d      = crc_q;
		rcrc_d     = rcrc_q;
		cmd_d      = cmd_q;
		mask_d     = mask_q;
		emit_data  = 1'b0;
		if (pos_q == 9'd0) begin
			start_ok_d = (b == START_BYTE);
		end else if (pos_q == 9'd1) begin
			addr_d = b;
		end else if (pos_q == 9'd2) begin
			len_d = b;
			crc_d = crc16_feed(16'h0000, b);
		end else if (pos_q < hdr_end) begin
			crc_d = crc16_feed(crc_q, b);
			if (idx == 9'd0) begin
				cmd_d = b;
			end else if (idx == 9'd1) begin
				mask_d = {mask_q[15:8], b};
			end else if (idx == 9'd2) begin
				mask_d = {b, mask_q[7:0]};
			end else begin
				emit_data = 1'b1;
			end
		end else if (pos_q == hdr_end) begin
			rcrc_d = crc_high_first_q ? {b, rcrc_q[7:0]} : {rcrc_q[15:8], b};
		end else if (pos_q == hdr_end + 9'd1) begin
			rcrc_d = crc_high_first_q ? {rcrc_q[15:8], b} : {b, rcrc_q[7:0]};
		end
	end

	assign bc = (addr_d == BROADCAST_ADDR);

	always_comb begin
		if (pos_q < 9'd4) begin
			st = ST_TOO_SHORT;
		end else if (!start_ok_d) begin
			st = ST_BAD_START;
		end else if (({1'b0, pos_q} + 10'd1) != (FRAME_OVERHEAD + {2'b00, len_d})) begin
			st = ST_BAD_LENGTH;
		end else if (rcrc_d != crc_d) begin
			st = ST_CRC_MISMATCH;
		end else if ((addr_d != device_id_q) && !bc) begin
			st = ST_NOT_ADDRESSED;
		end else if ({1'b0, len_d} < HEADER_BYTES) begin
			st = ST_PAYLOAD_SHORT;
		end else begin
			st = ST_ACCEPTED;
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (beat.frame_end) begin
			res_valid      = step;
			res.kind       = KIND_VERDICT;
			res.status     = st;
			res.command    = cmd_d;
			res.chan_mask  = mask_d;
			res.broadcast  = bc;
			res.data_count = fwd_q;
		end else if (emit_data) begin
			res_valid     = step;
			res.kind      = KIND_DATA;
			res.data_byte = b;
		end
	end

	assign pos_d = (pos_q < POS_MAX) ? pos_q + 9'd1 : pos_q;
	assign fwd_d = emit_data ? fwd_q + 8'd1 : fwd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			start_ok_q <= 1'b0;
			addr_q     <= '0;
			len_q      <= '0;
			crc_q      <= '0;
			rcrc_q     <= '0;
			cmd_q      <= '0;
			mask_q     <= '0;
			fwd_q      <= '0;
		end else if (step) begin
			if (beat.frame_end) begin
				pos_q      <= '0;
				start_ok_q <= 1'b0;
				addr_q     <= '0;
				len_q      <= '0;
				crc_q      <= '0;
				rcrc_q     <= '0;
				cmd_q      <= '0;
				mask_q     <= '0;
				fwd_q      <= '0;
			end else begin
				pos_q      <= pos_d;
				start_ok_q <= start_ok_d;
				addr_q     <= addr_d;
				len_q      <= len_d;
				crc_q      <= crc_d;
				rcrc_q     <= rcrc_d;
				cmd_q      <= cmd_d;
				mask_q     <= mask_d;
				fwd_q      <= fwd_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/afr_out_reg.sv
// Result register: holds one result beat until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module afr_out_reg
	import afr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire res_beat_t res_in,
	input  wire logic      out_stall,
	output logic           out_valid,
	output logic           free,
	output res_beat_t      res_q
);

	assign free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire

// File: src/addressed_frame_receiver_crc16_core.sv
// Top level of the addressed frame receiver with CRC-16/XMODEM check.
//
// channel  | handshake                   | payload
// ---------+-----------------------------+----------------------------------------------
// in       | in_valid / in_stall         | rx_byte, frame_end
// out      | out_valid / out_stall       | kind, data_byte, status, command,
//          |                             | chan_mask, broadcast, data_count
// cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One byte beat per cycle unless out_stall; results go from the input to the result register.
// The combinational CRC byte update between the input and result registers sets the rate.
// Reset clears all frame state and loads device_id 1, crc_high_first 0; no clearing pass.
// A stalled result holds the result register, and the input stalls only when a byte
// waits and the result register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module addressed_frame_receiver_crc16_core
	import afr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            rx_byte,
	input  wire logic                  frame_end,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       kind,
	output logic [7:0]                 data_byte,
	output logic [2:0]                 status,
	output logic [7:0]                 command,
	output logic [15:0]                chan_mask,
	output logic                       broadcast,
	output logic [7:0]                 data_count,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	in_beat_t  in_beat;
	in_beat_t  beat_s1;
	logic      valid_s1;
	logic      advance;
	logic      free;
	logic      res_valid;
	res_beat_t res;
	res_beat_t res_q;

	assign in_beat.rx_byte   = rx_byte;
	assign in_beat.frame_end = frame_end;
	assign advance           = valid_s1 && free;
	assign cfg_ready         = 1'b1;

	afr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_beat  (in_beat),
		.advance  (advance),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	afr_frame_core u_frame_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.beat      (beat_s1),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res)
	);

	afr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res_in    (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.free      (free),
		.res_q     (res_q)
	);

	assign kind       = res_q.kind;
	assign data_byte  = res_q.data_byte;
	assign status     = res_q.status;
	assign command    = res_q.command;
	assign chan_mask  = res_q.chan_mask;
	assign broadcast  = res_q.broadcast;
	assign data_count = res_q.data_count;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked result");

	a_held_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(beat_s1)))
		else $error("waiting input beat lost or changed");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> free)
		else $error("result loaded into a blocked result register");
`endif

endmodule

`default_nettype wire

// File: dv/addressed_frame_receiver_crc16_core_tb.sv
// Self-checking testbench for the addressed frame receiver with CRC-16/XMODEM check.
`timescale 1ns / 1ps

module addressed_frame_receiver_crc16_core_tb;
	import afr_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int PHASES          = 6;
	localparam int BEATS_PER_PHASE = 130;
	localparam int SETTLE_CYCLES   = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;

	typedef enum logic [1:0] {
		SRC_LIT,
		SRC_CRC_A,
		SRC_CRC_B
	} byte_src_t;

	typedef enum logic [2:0] {
		FLAW_NONE,
		FLAW_START,
		FLAW_CRC,
		FLAW_CUT,
		FLAW_EXTRA
	} frame_flaw_t;

	typedef struct packed {
		byte_src_t  src;
		logic [7:0] b;
		logic       last;
		logic       typed;
		res_beat_t  want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            rx_byte = 8'h00;
	logic                  frame_end = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  kind;
	logic [7:0]            data_byte;
	logic [2:0]            status;
	logic [7:0]            command;
	logic [15:0]           chan_mask;
	logic                  broadcast;
	logic [7:0]            data_count;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	addressed_frame_receiver_crc16_core i_dut (.*);

	// receiver copy: registers and per-frame state
	logic [7:0]  dev_id = DEVICE_ID_RST;
	logic        hi_first = 1'b0;
	logic [8:0]  frame_pos = '0;
	logic        start_seen = 1'b0;
	logic [7:0]  frame_addr = '0;
	logic [7:0]  frame_len = '0;
	logic [15:0] crc_run = '0;
	logic [15:0] crc_got = '0;
	logic [7:0]  cmd_held = '0;
	logic [15:0] mask_held = '0;
	logic [7:0]  fwd_cnt = '0;

	res_beat_t rx_results_due[$];
	dir_row_t  dir_tab[$];
	int        err_count = 0;
	int        results_seen = 0;
	int        bytes_sent = 0;
	int        cycle_cnt = 0;
	int        stall_left = 0;
	logic      tx_idle = 1'b1;
	logic      rx_idle = 1'b1;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
		logic fb;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic res_beat_t verdict(input status_t st, input logic [7:0] cmd,
			input logic [15:0] mask, input logic bc, input logic [7:0] cnt);
		res_beat_t r;
		r = '0;
		r.kind = KIND_VERDICT;
		r.status = st;
		r.command = cmd;
		r.chan_mask = mask;
		r.broadcast = bc;
		r.data_count = cnt;
		return r;
	endfunction

	// advance the frame state by one byte; return the data beat or verdict it causes
	task automatic deframe_predict(input logic [7:0] b, input logic last,
			output logic has_res, output res_beat_t res, output logic ignored);
		int      p;
		int      l;
		int      cnt;
		logic    fwd_now;
		logic    bc;
		status_t st;
		p = frame_pos;
		l = frame_len;
		has_res = 1'b0;
		res = '0;
		ignored = 1'b0;
		fwd_now = 1'b0;
		if (p == 0) begin
			start_seen = (b == START_BYTE);
		end else if (p == 1) begin
			frame_addr = b;
		end else if (p == 2) begin
			frame_len = b;
			crc_run = crc_next(16'h0000, b);
		end else if (p < HEADER_BYTES + l) begin
			crc_run = crc_next(crc_run, b);
			case (p - HEADER_BYTES)
				0: cmd_held = b;
				1: mask_held[7:0] = b;
				2: mask_held[15:8] = b;
				default: fwd_now = 1'b1;
			endcase
		end else if (p == HEADER_BYTES + l) begin
			if (hi_first) begin
				crc_got[15:8] = b;
			end else begin
				crc_got[7:0] = b;
			end
		end else if (p == HEADER_BYTES + l + 1) begin
			if (hi_first) begin
				crc_got[7:0] = b;
			end else begin
				crc_got[15:8] = b;
			end
		end else begin
			ignored = !last;
		end

		if (last) begin
			cnt = p + 1;
			bc = (frame_addr == BROADCAST_ADDR);
			if (cnt < FRAME_OVERHEAD) begin
				st = ST_TOO_SHORT;
			end else if (!start_seen) begin
				st = ST_BAD_START;
			end else if (cnt != FRAME_OVERHEAD + frame_len) begin
				st = ST_BAD_LENGTH;
			end else if (crc_got != crc_run) begin
				st = ST_CRC_MISMATCH;
			end else if (frame_addr != dev_id && !bc) begin
				st = ST_NOT_ADDRESSED;
			end else if (frame_len < HEADER_BYTES) begin
				st = ST_PAYLOAD_SHORT;
			end else begin
				st = ST_ACCEPTED;
			end
			res = verdict(st, cmd_held, mask_held, bc, fwd_cnt);
			has_res = 1'b1;
			frame_pos = '0;
			start_seen = 1'b0;
			frame_addr = '0;
			frame_len = '0;
			crc_run = '0;
			crc_got = '0;
			cmd_held = '0;
			mask_held = '0;
			fwd_cnt = '0;
		end else begin
			if (frame_pos < POS_MAX) begin
				frame_pos = frame_pos + 9'd1;
			end
			if (fwd_now) begin
				fwd_cnt = fwd_cnt + 8'd1;
				res.kind = KIND_DATA;
				res.data_byte = b;
				has_res = 1'b1;
			end
		end
	endtask

	task automatic report(input string msg);
		err_count++;
		if (err_count <= 40) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	task automatic cmp(input string field, input logic [15:0] got, input logic [15:0] want);
		if (got !== want) begin
			report($sformatf("result %0d %s: got %0h, expected %0h",
				results_seen, field, got, want));
		end
	endtask

	task automatic send_beat(input logic [7:0] b, input logic last,
			input logic typed = 1'b0, input res_beat_t want = '0);
		logic      has_res;
		logic      ignored;
		res_beat_t pred;
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_end <= last;
		do @(posedge clk); while (in_stall);
		deframe_predict(b, last, has_res, pred, ignored);
		if (typed) begin
			rx_results_due.insert(rx_results_due.size(), want);
		end else if (has_res) begin
			rx_results_due.insert(rx_results_due.size(), pred);
		end
		if (!ignored) begin
			bytes_sent++;
		end
	endtask

	task automatic send_frame(input int len, input logic [7:0] addr,
			input frame_flaw_t flaw, input int extra);
		logic [7:0]  raw[$];
		logic [15:0] c;
		logic [7:0]  r;
		int          n;
		int          k;
		raw.insert(raw.size(), START_BYTE);
		raw.insert(raw.size(), addr);
		raw.insert(raw.size(), len[7:0]);
		c = crc_next(16'h0000, len[7:0]);
		for (k = 0; k < len; k++) begin
			r = 8'($urandom);
			raw.insert(raw.size(), r);
			c = crc_next(c, r);
		end
		if (hi_first) begin
			raw.insert(raw.size(), c[15:8]);
			raw.insert(raw.size(), c[7:0]);
		end else begin
			raw.insert(raw.size(), c[7:0]);
			raw.insert(raw.size(), c[15:8]);
		end
		n = raw.size();
		case (flaw)
			FLAW_START: raw[0] = raw[0] ^ (8'h01 << $urandom_range(0, 7));
			FLAW_CRC: begin
				k = $urandom_range(3, n - 1);
				raw[k] = raw[k] ^ (8'h01 << $urandom_range(0, 7));
			end
			FLAW_CUT: n = $urandom_range(1, n - 1);
			FLAW_EXTRA: begin
				for (k = 0; k < extra; k++) begin
					raw.insert(raw.size(), 8'($urandom));
				end
				n = raw.size();
			end
			default: ;
		endcase
		for (k = 0; k < n; k++) begin
			send_beat(raw[k], k == n - 1);
		end
	endtask

	task automatic random_frame(input logic quiet);
		int          pick;
		int          len;
		int          n;
		logic [7:0]  addr;
		logic [7:0]  b;
		frame_flaw_t flaw;
		tx_idle = !quiet && $urandom_range(0, 3) != 0;
		rx_idle = !quiet && $urandom_range(0, 3) != 0;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			n = $urandom_range(1, 8);
			for (int k = 0; k < n; k++) begin
				b = 8'($urandom);
				if (k == 0 && $urandom_range(0, 1) == 0) begin
					b = START_BYTE;
				end
				send_beat(b, k == n - 1);
			end
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				len = $urandom_range(0, 10);
			end else if (pick < 97) begin
				len = $urandom_range(11, 40);
			end else begin
				len = $urandom_range(200, 255);
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				addr = dev_id;
			end else if (pick < 70) begin
				addr = BROADCAST_ADDR;
			end else begin
				addr = 8'($urandom);
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				flaw = FLAW_NONE;
			end else if (pick < 78) begin
				flaw = FLAW_START;
			end else if (pick < 86) begin
				flaw = FLAW_CRC;
			end else if (pick < 93) begin
				flaw = FLAW_CUT;
			end else begin
				flaw = FLAW_EXTRA;
			end
			send_frame(len, addr, flaw, $urandom_range(1, 4));
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (rx_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_DEVICE_ID:      dev_id = val;
			REG_CRC_HIGH_FIRST: hi_first = val[0];
			default: ;
		endcase
	endtask

	task automatic row(input byte_src_t src, input logic [7:0] b, input logic last,
			input logic typed = 1'b0, input res_beat_t want = '0);
		dir_tab.insert(dir_tab.size(), {src, b, last, typed, want});
	endtask

	always @(posedge clk) begin
		if (!rx_idle) begin
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 16);
		end
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin : watch_results
		res_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (rx_results_due.size() == 0) begin
				report($sformatf("unexpected result: kind %0d data %0h status %0d",
					kind, data_byte, status));
			end else begin
				want = rx_results_due.pop_front();
				cmp("kind", 16'(kind), 16'(want.kind));
				cmp("data_byte", 16'(data_byte), 16'(want.data_byte));
				cmp("status", 16'(status), 16'(want.status));
				cmp("command", 16'(command), 16'(want.command));
				cmp("chan_mask", chan_mask, want.chan_mask);
				cmp("broadcast", 16'(broadcast), 16'(want.broadcast));
				cmp("data_count", 16'(data_count), 16'(want.data_count));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("addressed_frame_receiver_crc16_core regression: fail");
			$finish;
		end
	end

	initial begin : run
		logic [7:0] b;
		int         goal;

		// too short: a lone byte
		row(SRC_LIT, 8'h00, 1'b1, 1'b1, verdict(ST_TOO_SHORT, 8'h00, 16'h0000, 1'b0, 8'd0));
		// accepted, one data byte forwarded
		row(SRC_LIT, START_BYTE, 1'b0);
		row(SRC_LIT, 8'h01, 1'b0);
		row(SRC_LIT, 8'h04, 1'b0);
		row(SRC_LIT, 8'hFF, 1'b0);
		row(SRC_LIT, 8'h00, 1'b0);
		row(SRC_LIT, 8'hFF, 1'b0);
		row(SRC_LIT, 8'h00, 1'b0);
		row(SRC_CRC_A, 8'h00, 1'b0);
		row(SRC_CRC_B, 8'h00, 1'b1, 1'b1,
			verdict(ST_ACCEPTED, 8'hFF, 16'hFF00, 1'b0, 8'd1));
		// bad start byte, broadcast address
		row(SRC_LIT, 8'h00, 1'b0);
		row(SRC_LIT, BROADCAST_ADDR, 1'b0);
		row(SRC_LIT, 8'h00, 1'b0);
		row(SRC_LIT, 8'h00, 1'b0);
		row(SRC_LIT, 8'h00, 1'b1, 1'b1, verdict(ST_BAD_START, 8'h00, 16'h0000, 1'b1, 8'd0));
		// end lands on a data byte: not forwarded
		row(SRC_LIT, START_BYTE, 1'b0);
		row(SRC_LIT, 8'h01, 1'b0);
		row(SRC_LIT, 8'h04, 1'b0);
		row(SRC_LIT, 8'h11, 1'b0);
		row(SRC_LIT, 8'h22, 1'b0);
		row(SRC_LIT, 8'h33, 1'b0);
		row(SRC_LIT, 8'h44, 1'b1, 1'b1, verdict(ST_BAD_LENGTH, 8'h11, 16'h3322, 1'b0, 8'd0));
		// CRC mismatch wins over the address check
		row(SRC_LIT, START_BYTE, 1'b0);
		row(SRC_LIT, 8'h02, 1'b0);
		row(SRC_LIT, 8'h00, 1'b0);
		row(SRC_LIT, 8'hFF, 1'b0);
		row(SRC_LIT, 8'hFF, 1'b1, 1'b1,
			verdict(ST_CRC_MISMATCH, 8'h00, 16'h0000, 1'b0, 8'd0));
		// wrong address wins over the payload size check
		row(SRC_LIT, START_BYTE, 1'b0);
		row(SRC_LIT, 8'h02, 1'b0);
		row(SRC_LIT, 8'h00, 1'b0);
		row(SRC_CRC_A, 8'h00, 1'b0);
		row(SRC_CRC_B, 8'h00, 1'b1, 1'b1,
			verdict(ST_NOT_ADDRESSED, 8'h00, 16'h0000, 1'b0, 8'd0));
		// broadcast with only the command byte
		row(SRC_LIT, START_BYTE, 1'b0);
		row(SRC_LIT, BROADCAST_ADDR, 1'b0);
		row(SRC_LIT, 8'h01, 1'b0);
		row(SRC_LIT, 8'h5A, 1'b0);
		row(SRC_CRC_A, 8'h00, 1'b0);
		row(SRC_CRC_B, 8'h00, 1'b1, 1'b1,
			verdict(ST_PAYLOAD_SHORT, 8'h5A, 16'h0000, 1'b1, 8'd0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			case (dir_tab[i].src)
				SRC_CRC_A: b = hi_first ? crc_run[15:8] : crc_run[7:0];
				SRC_CRC_B: b = hi_first ? crc_run[7:0] : crc_run[15:8];
				default:   b = dir_tab[i].b;
			endcase
			send_beat(b, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
		end
		drain_results();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_DEVICE_ID, 8'd0);
					write_reg(REG_CRC_HIGH_FIRST, 8'hFF);
				end
				1: begin
					write_reg(REG_DEVICE_ID, 8'd254);
					write_reg(REG_CRC_HIGH_FIRST, 8'hFE);
					write_reg(REG_SPARE, 8'h55);
				end
				default: begin
					write_reg(REG_DEVICE_ID, 8'($urandom_range(0, 254)));
					write_reg(REG_CRC_HIGH_FIRST, 8'($urandom));
				end
			endcase
			tx_idle = 1'b1;
			rx_idle = 1'b1;
			// longest payload, then a frame running past position saturation
			if (phase == 0) begin
				send_frame(255, BROADCAST_ADDR, FLAW_NONE, 0);
			end
			if (phase == 1) begin
				send_frame(4, dev_id, FLAW_EXTRA, 520);
			end
			goal = bytes_sent + BEATS_PER_PHASE;
			while (bytes_sent < goal) begin
				random_frame(phase == PHASES - 1);
			end
			drain_results();
		end

		if (err_count == 0) begin
			$display("addressed_frame_receiver_crc16_core regression: pass");
		end else begin
			$display("addressed_frame_receiver_crc16_core regression: fail");
		end
		$finish;
	end

endmodule
